>>> rtl/hecm_pkg.sv
package hecm_pkg;

  localparam int KIND_W   = 2;
  localparam int RED_W    = 8;
  localparam int RED_N    = 256;
  localparam int LOG_FRAC = 44;
  // log2 of 255 stays below 8, so three integer bits
  localparam int LOG_W    = LOG_FRAC + 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT  = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TOP_CLEAR,
    TOP_IDLE,
    TOP_CNT_WR,
    TOP_SUM,
    TOP_SUM_LAST,
    TOP_HUE_GO,
    TOP_HUE_WAIT,
    TOP_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    HU_IDLE,
    HU_DIV,
    HU_MUL,
    HU_SRCH,
    HU_DONE
  } hu_state_t;

  typedef logic [LOG_W-1:0] log_tab_t [RED_N];

  // log2 of x with LOG_FRAC fraction bits, truncated, by repeated squaring
  function automatic logic [63:0] fixed_log2(input int unsigned x);
    logic [63:0]  m;
    logic [63:0]  val;
    logic [127:0] sq;
    int unsigned  k;
    k = 0;
    while (k < 7 && (x >> (k + 1)) != 0) k++;
    m   = 64'(x) << (62 - k);
    val = 64'(k);
    for (int i = 0; i < LOG_FRAC; i++) begin
      sq  = 128'(m) * 128'(m);
      m   = sq[125:62];
      val = val << 1;
      if (m[63]) begin
        m      = m >> 1;
        val[0] = 1'b1;
      end
    end
    return val;
  endfunction

  function automatic log_tab_t build_logs();
    log_tab_t t;
    t[0] = '0;
    for (int r = 1; r < RED_N; r++) t[r] = LOG_W'(fixed_log2(r));
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_logs();

endpackage

>>> rtl/hecm_in_if.sv
interface hecm_in_if #(
  parameter int CNT_W = 11
);
  logic                        valid;
  logic                        ready;
  logic [hecm_pkg::KIND_W-1:0] kind;
  logic [CNT_W-1:0]            iteration_count;

  modport source (output valid, kind, iteration_count, input ready);
  modport sink   (input valid, kind, iteration_count, output ready);
endinterface

>>> rtl/hecm_out_if.sv
interface hecm_out_if #(
  parameter int HUE_W = 11
);
  logic                       valid;
  logic                       ready;
  logic [HUE_W-1:0]           hue_fraction;
  logic [hecm_pkg::RED_W-1:0] red;

  modport source (output valid, hue_fraction, red, input ready);
  modport sink   (input valid, hue_fraction, red, output ready);
endinterface

>>> rtl/histogram_equalized_colour_map.sv
// Histogram-equalized colour map. A count transfer adds one to the bin of
// its escape count and to the pixel total (both saturate; the never-escaped
// count is skipped). A colour transfer sums bins 0 up to its count (clipped
// to the top bin), one memory read per cycle, then, unless the hue comes
// out as zero or one, runs a bit-per-cycle divider for the hue, and an
// 8-step table search for red. A clear transfer, and reset itself, sweep
// the bin memory one entry a cycle, taking no input until the sweep ends.
// The result sits in an output register, so the next input is taken while
// it waits.
module histogram_equalized_colour_map #(
  parameter int MAX_COUNT = 1024,
  parameter int BIN_WIDTH = 24,
  parameter int HUE_BITS  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  hecm_in_if.sink     in_ch,
  hecm_out_if.source  out_ch
);
  import hecm_pkg::*;

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int AW    = $clog2(MAX_COUNT);
  localparam int SUM_W = BIN_WIDTH + AW;

  logic [BIN_WIDTH-1:0] bin_mem [MAX_COUNT];
  logic [BIN_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [BIN_WIDTH-1:0] wr_data;
  logic                 wr_en;

  top_state_t           state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 pend_r, pend_nxt;
  logic [BIN_WIDTH-1:0] total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [HUE_BITS:0]    out_hue_r;
  logic [RED_W-1:0]     out_red_r;
  logic                 out_load;

  logic [CNT_W-1:0]     in_cnt;
  logic                 in_ready;
  logic                 in_xfer;
  logic                 in_big;
  logic [BIN_WIDTH-1:0] bin_inc;
  logic [BIN_WIDTH-1:0] total_inc;

  logic                 hue_start;
  logic                 hue_done;
  logic [HUE_BITS:0]    hue_val;
  logic [RED_W-1:0]     red_val;

  assign in_cnt    = in_ch.iteration_count;
  assign in_ready  = (state_r == TOP_IDLE);
  assign in_ch.ready = in_ready;
  assign in_xfer   = in_ch.valid && in_ready;
  assign in_big    = in_cnt >= CNT_W'(MAX_COUNT);
  assign bin_inc   = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  assign total_inc = (total_r == '1) ? total_r : total_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    rd_addr   = idx_r;
    wr_addr   = idx_r;
    wr_data   = '0;
    wr_en     = 1'b0;
    hue_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      TOP_CLEAR: begin
        wr_en     = 1'b1;
        total_nxt = '0;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == AW'(MAX_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = TOP_IDLE;
        end
      end
      TOP_IDLE: begin
        rd_addr = in_cnt[AW-1:0];
        if (in_xfer) begin
          case (in_ch.kind)
            KIND_COUNT: begin
              if (!in_big) begin
                idx_nxt   = in_cnt[AW-1:0];
                state_nxt = TOP_CNT_WR;
              end
            end
            KIND_COLOUR: begin
              last_nxt  = in_big ? AW'(MAX_COUNT - 1) : in_cnt[AW-1:0];
              idx_nxt   = '0;
              sum_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = TOP_SUM;
            end
            KIND_CLEAR: begin
              idx_nxt   = '0;
              total_nxt = '0;
              state_nxt = TOP_CLEAR;
            end
            default: state_nxt = TOP_IDLE;
          endcase
        end
      end
      TOP_CNT_WR: begin
        // read data for this bin arrived; write back the saturated increment
        wr_en     = 1'b1;
        wr_data   = bin_inc;
        total_nxt = total_inc;
        idx_nxt   = '0;
        state_nxt = TOP_IDLE;
      end
      TOP_SUM: begin
        pend_nxt = 1'b1;
        if (pend_r) sum_nxt = sum_r + SUM_W'(rd_data_r);
        if (idx_r == last_r) state_nxt = TOP_SUM_LAST;
        else idx_nxt = idx_r + 1'b1;
      end
      TOP_SUM_LAST: begin
        sum_nxt   = sum_r + SUM_W'(rd_data_r);
        pend_nxt  = 1'b0;
        idx_nxt   = '0;
        state_nxt = TOP_HUE_GO;
      end
      TOP_HUE_GO: begin
        hue_start = 1'b1;
        state_nxt = TOP_HUE_WAIT;
      end
      TOP_HUE_WAIT: begin
        if (hue_done) state_nxt = TOP_EMIT;
      end
      TOP_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = TOP_IDLE;
        end
      end
      default: state_nxt = TOP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) bin_mem[wr_addr] <= wr_data;
    rd_data_r <= bin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    sum_r  <= sum_nxt;
    if (out_load) begin
      out_hue_r <= hue_val;
      out_red_r <= red_val;
    end
  end

  hecm_hue #(
    .BIN_WIDTH (BIN_WIDTH),
    .SUM_W     (SUM_W),
    .HUE_BITS  (HUE_BITS)
  ) u_hue (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hue_start),
    .sum   (sum_r),
    .total (total_r),
    .done  (hue_done),
    .hue   (hue_val),
    .red   (red_val)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hue_fraction = out_hue_r;
  assign out_ch.red          = out_red_r;

  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.kind == KIND_CLEAR) |=> (total_r == '0 && state_r == TOP_CLEAR))
    else $error("clear transfer did not start the sweep");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == TOP_EMIT))
    else $error("result raised outside emit");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TOP_SUM) |-> idx_r <= last_r)
    else $error("sum index ran past the last bin");

endmodule

>>> rtl/hecm_hue.sv
module hecm_hue #(
  parameter int BIN_WIDTH = 24,
  parameter int SUM_W     = 34,
  parameter int HUE_BITS  = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           sum,
  input  logic [BIN_WIDTH-1:0]       total,
  output logic                       done,
  output logic [HUE_BITS:0]          hue,
  output logic [hecm_pkg::RED_W-1:0] red
);
  import hecm_pkg::*;

  localparam int STEP_W = $clog2(HUE_BITS);
  localparam int BIT_W  = $clog2(RED_W);
  localparam int TGT_W  = LOG_W + HUE_BITS + 1;

  hu_state_t             state_r, state_nxt;
  logic [BIN_WIDTH-1:0]  rem_r, rem_nxt;
  logic [HUE_BITS:0]     hue_r, hue_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [TGT_W-1:0]      target_r, target_nxt;
  logic [RED_W-1:0]      red_r, red_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;

  logic [BIN_WIDTH:0]    shifted;
  logic                  ge;
  logic [RED_W-1:0]      cand;
  logic [TGT_W-1:0]      thresh;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, total};
  assign cand    = red_r | (RED_W'(1) << bit_r);
  assign thresh  = TGT_W'({LOG_TAB[cand], {HUE_BITS{1'b0}}});

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    hue_nxt    = hue_r;
    step_nxt   = step_r;
    target_nxt = target_r;
    red_nxt    = red_r;
    bit_nxt    = bit_r;
    done       = 1'b0;
    case (state_r)
      HU_IDLE: begin
        if (start) begin
          rem_nxt  = sum[BIN_WIDTH-1:0];
          step_nxt = '0;
          if (total == '0) begin
            hue_nxt   = '0;
            state_nxt = HU_MUL;
          end else if (sum >= SUM_W'(total)) begin
            hue_nxt   = (HUE_BITS+1)'(1) << HUE_BITS;
            state_nxt = HU_MUL;
          end else begin
            hue_nxt   = '0;
            state_nxt = HU_DIV;
          end
        end
      end
      HU_DIV: begin
        // one quotient bit per cycle, restoring
        rem_nxt  = ge ? BIN_WIDTH'(shifted - {1'b0, total}) : shifted[BIN_WIDTH-1:0];
        hue_nxt  = {hue_r[HUE_BITS-1:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(HUE_BITS - 1)) state_nxt = HU_MUL;
      end
      HU_MUL: begin
        target_nxt = TGT_W'(hue_r) * TGT_W'(LOG_TAB[RED_N-1]);
        red_nxt    = '0;
        bit_nxt    = BIT_W'(RED_W - 1);
        state_nxt  = HU_SRCH;
      end
      HU_SRCH: begin
        // binary search for the largest red whose scaled log fits the target
        if (thresh <= target_r) red_nxt = cand;
        if (bit_r == '0) state_nxt = HU_DONE;
        else bit_nxt = bit_r - 1'b1;
      end
      HU_DONE: begin
        done      = 1'b1;
        state_nxt = HU_IDLE;
      end
      default: state_nxt = HU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= HU_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    hue_r    <= hue_nxt;
    step_r   <= step_nxt;
    target_r <= target_nxt;
    red_r    <= red_nxt;
    bit_r    <= bit_nxt;
  end

  assign hue = hue_r;
  assign red = red_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> hue_r <= ((HUE_BITS+1)'(1) << HUE_BITS))
    else $error("hue above one");

  a_red_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> red_r != '0)
    else $error("red search ended at zero");

  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == HU_IDLE && start && total == '0) |=> hue_r == '0)
    else $error("empty histogram must give zero hue");

endmodule
